// File: rtl/wsfd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
`timescale 1ns / 1ps
package wsfd_pkg;

  localparam int unsigned LenW    = 64;
  localparam int unsigned MaxLenW = 63;

  localparam logic [MaxLenW-1:0] MaxLenReset = 63'd65536;

  localparam logic [2:0] KindData   = 3'd0;
  localparam logic [2:0] KindPing   = 3'd1;
  localparam logic [2:0] KindEmpty  = 3'd2;
  localparam logic [2:0] KindClose  = 3'd3;
  localparam logic [2:0] KindError  = 3'd4;

  localparam logic [3:0] OpCont  = 4'h0;
  localparam logic [3:0] OpText  = 4'h1;
  localparam logic [3:0] OpBin   = 4'h2;
  localparam logic [3:0] OpClose = 4'h8;
  localparam logic [3:0] OpPing  = 4'h9;
  localparam logic [3:0] OpPong  = 4'hA;

  localparam logic [6:0] Len7Ext16 = 7'd126;
  localparam logic [6:0] Len7Ext64 = 7'd127;

  localparam logic [3:0] ExtBytes16 = 4'd2;
  localparam logic [3:0] ExtBytes64 = 4'd8;
  localparam logic [3:0] KeyBytes   = 4'd4;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic [3:0] opcode;
    logic       frame_last;
    logic       message_last;
  } result_t;

  function automatic logic is_data_op(input logic [3:0] oc);
    return (oc == OpCont) || (oc == OpText) || (oc == OpBin);
  endfunction

endpackage

// File: rtl/wsfd_parser.sv
// Header parser, length check and payload unmasking for one byte per transfer.
`timescale 1ns / 1ps
module wsfd_parser (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  logic [7:0]               in_byte_i,
  input  logic                     cfg_we_i,
  input  logic [62:0]              cfg_wdata_i,
  output logic                     res_valid_o,
  output wsfd_pkg::result_t        res_o
);
  import wsfd_pkg::*;

  localparam logic [2:0] PhFirst   = 3'd0;
  localparam logic [2:0] PhSecond  = 3'd1;
  localparam logic [2:0] PhExtLen  = 3'd2;
  localparam logic [2:0] PhKey     = 3'd3;
  localparam logic [2:0] PhPayload = 3'd4;

  logic [2:0]         phase_q, phase_d;
  logic [3:0]         op_q, op_d;
  logic               fin_q, fin_d;
  logic               masked_q, masked_d;
  logic [31:0]        key_q, key_d;
  logic [3:0]         ext_q, ext_d;
  logic [LenW-1:0]    rem_q, rem_d;
  logic [1:0]         idx_q, idx_d;
  logic               down_q, down_d;
  logic [MaxLenW-1:0] max_len_q;

  logic [LenW-1:0]    len_now;
  logic               len_done;
  logic               mask_now;
  logic               too_long;
  logic [LenW-1:0]    rem_dec;
  logic [7:0]         key_byte;
  logic               flast;
  logic [3:0]         oc;
  result_t            res;
  logic               res_valid;

  always_comb begin
    len_now  = (phase_q == PhSecond) ? {57'd0, in_byte_i[6:0]} : {rem_q[55:0], in_byte_i};
    too_long = len_now > {1'b0, max_len_q};
    rem_dec  = (rem_q == '0) ? '0 : rem_q - 64'd1;
    flast    = (rem_dec == '0);
    oc       = in_byte_i[3:0];
    case (idx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    op_d      = op_q;
    fin_d     = fin_q;
    masked_d  = masked_q;
    key_d     = key_q;
    ext_d     = ext_q;
    rem_d     = rem_q;
    idx_d     = idx_q;
    down_d    = down_q;
    res_valid = 1'b0;
    res       = '0;
    len_done  = 1'b0;
    mask_now  = masked_q;

    if (!down_q) begin
      case (phase_q)
        PhSecond: begin
          masked_d = in_byte_i[7];
          mask_now = in_byte_i[7];
          rem_d    = '0;
          if (in_byte_i[6:0] == Len7Ext64) begin
            ext_d   = ExtBytes64;
            phase_d = PhExtLen;
          end else if (in_byte_i[6:0] == Len7Ext16) begin
            ext_d   = ExtBytes16;
            phase_d = PhExtLen;
          end else begin
            rem_d    = len_now;
            len_done = 1'b1;
          end
        end
        PhExtLen: begin
          rem_d = len_now;
          ext_d = (ext_q > 4'd0) ? ext_q - 4'd1 : ext_q;
          if (ext_q <= 4'd1) begin
            len_done = 1'b1;
          end
        end
        PhKey: begin
          key_d = {key_q[23:0], in_byte_i};
          ext_d = (ext_q > 4'd0) ? ext_q - 4'd1 : ext_q;
          if (ext_q <= 4'd1) begin
            idx_d = 2'd0;
            if (rem_q == '0) begin
              phase_d          = PhFirst;
              res_valid        = 1'b1;
              res.kind         = KindEmpty;
              res.opcode       = op_q;
              res.frame_last   = 1'b1;
              res.message_last = fin_q && is_data_op(op_q);
            end else begin
              phase_d = PhPayload;
            end
          end
        end
        PhPayload: begin
          idx_d            = idx_q + 2'd1;
          rem_d            = rem_dec;
          res_valid        = 1'b1;
          res.kind         = (op_q == OpPing) ? KindPing : KindData;
          res.data_byte    = masked_q ? (in_byte_i ^ key_byte) : in_byte_i;
          res.opcode       = op_q;
          res.frame_last   = flast;
          res.message_last = flast && fin_q && is_data_op(op_q);
          if (flast) begin
            phase_d = PhFirst;
          end
        end
        default: begin
          phase_d = PhFirst;
          if (oc == OpClose) begin
            op_d       = oc;
            fin_d      = in_byte_i[7];
            down_d     = 1'b1;
            res_valid  = 1'b1;
            res.kind   = KindClose;
            res.opcode = oc;
          end else if (!(is_data_op(oc) || oc == OpPing || oc == OpPong)) begin
            down_d     = 1'b1;
            res_valid  = 1'b1;
            res.kind   = KindError;
            res.opcode = oc;
          end else begin
            op_d    = oc;
            fin_d   = in_byte_i[7];
            phase_d = PhSecond;
          end
        end
      endcase

      if (len_done) begin
        if (too_long) begin
          down_d     = 1'b1;
          phase_d    = PhFirst;
          res_valid  = 1'b1;
          res.kind   = KindError;
          res.opcode = op_q;
        end else if (mask_now) begin
          phase_d = PhKey;
          ext_d   = KeyBytes;
          key_d   = '0;
        end else begin
          idx_d = 2'd0;
          if (len_now == '0) begin
            phase_d          = PhFirst;
            res_valid        = 1'b1;
            res.kind         = KindEmpty;
            res.opcode       = op_q;
            res.frame_last   = 1'b1;
            res.message_last = fin_q && is_data_op(op_q);
          end else begin
            phase_d = PhPayload;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhFirst;
      op_q     <= '0;
      fin_q    <= 1'b0;
      masked_q <= 1'b0;
      key_q    <= '0;
      ext_q    <= '0;
      rem_q    <= '0;
      idx_q    <= '0;
      down_q   <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      op_q     <= op_d;
      fin_q    <= fin_d;
      masked_q <= masked_d;
      key_q    <= key_d;
      ext_q    <= ext_d;
      rem_q    <= rem_d;
      idx_q    <= idx_d;
      down_q   <= down_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  assign res_valid_o = res_valid;
  assign res_o       = res;

endmodule

// File: rtl/websocket_frame_deframer.sv
// Top level of the WebSocket frame deframer: byte parser and result output stage.
`timescale 1ns / 1ps
// Accepts one received byte per transfer, a byte in every clock cycle while the
// skid register is empty. Each byte yields at most one result, held in the output
// register, or in the skid register if the output is stalled. A two-entry output
// stage (output register plus skid register) lets input keep flowing while one
// result waits; input stalls only when both entries are full. Payload bytes come
// out unmasked; empty frames, close and protocol errors come out as events. After
// a close or an error, bytes are still taken but produce nothing until reset.
// Write max_frame_len through cfg_we_i only while the block is idle.
module websocket_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [3:0]  opcode_o,
  output logic        frame_last_o,
  output logic        message_last_o,
  input  logic        cfg_we_i,
  input  logic [62:0] cfg_wdata_i
);
  import wsfd_pkg::*;

  logic    step;
  logic    res_valid;
  result_t res;
  logic    pop;
  logic    push;

  logic    out_valid_q;
  result_t out_q;
  logic    skid_valid_q;
  result_t skid_q;

  assign in_ready_o = !skid_valid_q;
  assign step       = in_valid_i && in_ready_o;
  assign pop        = out_valid_q && out_ready_i;
  assign push       = step && res_valid;

  wsfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .in_byte_i   (in_byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_q.kind;
  assign data_byte_o    = out_q.data_byte;
  assign opcode_o       = out_q.opcode;
  assign frame_last_o   = out_q.frame_last;
  assign message_last_o = out_q.message_last;

endmodule

// File: tb/websocket_frame_deframer_tb.sv
// Self-checking testbench for the WebSocket frame deframer: directed and random frame streams.
`timescale 1ns / 1ps
module websocket_frame_deframer_tb;
  import wsfd_pkg::*;

  typedef enum logic [2:0] {PhHead, PhLen, PhExtLen, PhKey, PhPayload} parse_phase_e;
  typedef enum {Enc7, Enc16, Enc64} len_enc_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  kind_o;
  logic [7:0]  data_byte_o;
  logic [3:0]  opcode_o;
  logic        frame_last_o;
  logic        message_last_o;
  logic        cfg_we_i = 1'b0;
  logic [62:0] cfg_wdata_i = '0;

  websocket_frame_deframer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .data_byte_o   (data_byte_o),
    .opcode_o      (opcode_o),
    .frame_last_o  (frame_last_o),
    .message_last_o(message_last_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Parser state mirrored from the stream of transferred bytes.
  parse_phase_e phase = PhHead;
  logic [3:0]   cur_op = '0;
  logic         cur_fin = 1'b0;
  logic         cur_masked = 1'b0;
  logic [31:0]  key_word = '0;
  logic [3:0]   bytes_left = '0;
  logic [63:0]  len_left = '0;
  logic [1:0]   key_pos = '0;
  logic         halted = 1'b0;
  logic [62:0]  max_len = MaxLenReset;

  result_t deframed_q[$];
  int      errors = 0;
  int      bytes_sent = 0;
  bit      in_steady = 1'b0;
  bit      out_steady = 1'b0;
  int      stall_left = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("websocket_frame_deframer_tb NOT OK");
    $finish;
  end

  function automatic logic op_known(input logic [3:0] oc);
    return oc == OpCont || oc == OpText || oc == OpBin || oc == OpPing || oc == OpPong;
  endfunction

  function automatic int pick_gap(input bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report(input string what);
    errors++;
    $display("%0t: mismatch: %s", $time, what);
  endtask

  task automatic push_result(input logic [2:0] kind, input logic [7:0] d,
                             input logic [3:0] oc, input logic flast);
    result_t r;
    r.kind         = kind;
    r.data_byte    = d;
    r.opcode       = oc;
    r.frame_last   = flast;
    r.message_last = flast && cur_fin && (oc == OpCont || oc == OpText || oc == OpBin);
    deframed_q.push_back(r);
  endtask

  task automatic raise_error(input logic [3:0] oc);
    halted = 1'b1;
    phase  = PhHead;
    push_result(KindError, 8'h00, oc, 1'b0);
  endtask

  task automatic begin_payload();
    key_pos = '0;
    if (len_left == 64'd0) begin
      phase = PhHead;
      push_result(KindEmpty, 8'h00, cur_op, 1'b1);
    end else begin
      phase = PhPayload;
    end
  endtask

  task automatic finish_length();
    if (len_left > {1'b0, max_len}) begin
      raise_error(cur_op);
    end else if (cur_masked) begin
      phase      = PhKey;
      bytes_left = KeyBytes;
      key_word   = '0;
    end else begin
      begin_payload();
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0] d;
    if (halted) return;
    case (phase)
      PhLen: begin
        cur_masked = b[7];
        len_left   = '0;
        if (b[6:0] == Len7Ext64) begin
          bytes_left = ExtBytes64;
          phase      = PhExtLen;
        end else if (b[6:0] == Len7Ext16) begin
          bytes_left = ExtBytes16;
          phase      = PhExtLen;
        end else begin
          len_left = {57'd0, b[6:0]};
          finish_length();
        end
      end
      PhExtLen: begin
        len_left   = {len_left[55:0], b};
        bytes_left = bytes_left - 4'd1;
        if (bytes_left == 4'd0) finish_length();
      end
      PhKey: begin
        key_word   = {key_word[23:0], b};
        bytes_left = bytes_left - 4'd1;
        if (bytes_left == 4'd0) begin_payload();
      end
      PhPayload: begin
        d        = cur_masked ? b ^ key_word[8*(3-key_pos) +: 8] : b;
        key_pos  = key_pos + 2'd1;
        len_left = len_left - 64'd1;
        if (len_left == 64'd0) phase = PhHead;
        push_result(cur_op == OpPing ? KindPing : KindData, d, cur_op, len_left == 64'd0);
      end
      default: begin
        if (b[3:0] == OpClose) begin
          cur_op  = b[3:0];
          cur_fin = b[7];
          halted  = 1'b1;
          phase   = PhHead;
          push_result(KindClose, 8'h00, b[3:0], 1'b0);
        end else if (!op_known(b[3:0])) begin
          raise_error(b[3:0]);
        end else begin
          cur_op  = b[3:0];
          cur_fin = b[7];
          phase   = PhLen;
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic check_result();
    result_t want;
    if (deframed_q.size() == 0) begin
      report($sformatf("unexpected result kind %0d byte %02h", kind_o, data_byte_o));
      return;
    end
    want = deframed_q.pop_front();
    check_field("kind", {5'd0, kind_o}, {5'd0, want.kind});
    check_field("data_byte", data_byte_o, want.data_byte);
    check_field("opcode", {4'd0, opcode_o}, {4'd0, want.opcode});
    check_field("frame_last", {7'd0, frame_last_o}, {7'd0, want.frame_last});
    check_field("message_last", {7'd0, message_last_o}, {7'd0, want.message_last});
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_result();
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      stall_left  <= pick_gap(out_steady);
    end
    if ($urandom_range(0, 63) == 0) out_steady <= ~out_steady;
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap(in_steady);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    deframe_byte(b);
    bytes_sent++;
    if (bytes_sent % 48 == 0) in_steady = ($urandom_range(0, 3) == 0);
  endtask

  task automatic set_max_len(input logic [62:0] v);
    in_valid_i <= 1'b0;
    while (deframed_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    max_len = v;
  endtask

  task automatic send_frame(input logic [3:0] oc, input logic fin, input logic masked,
                            input logic [63:0] len, input len_enc_e enc,
                            input logic [31:0] key);
    logic [2:0] rsv;
    logic [6:0] len7;
    rsv  = 3'($urandom_range(0, 7));
    len7 = enc == Enc64 ? Len7Ext64 : enc == Enc16 ? Len7Ext16 : len[6:0];
    send_byte({fin, rsv, oc});
    send_byte({masked, len7});
    if (enc == Enc64) begin
      for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
    end else if (enc == Enc16) begin
      for (int i = 1; i >= 0; i--) send_byte(len[8*i +: 8]);
    end
    if (masked) begin
      for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    end
    for (longint unsigned n = 0; n < len; n++) send_byte(8'($urandom));
  endtask

  task automatic send_random_frame();
    logic [3:0]  oc;
    logic [63:0] len;
    len_enc_e    enc;
    int          r;
    case ($urandom_range(0, 7))
      0, 1: oc = OpText;
      2, 3: oc = OpBin;
      4, 5: oc = OpCont;
      6: oc = OpPing;
      default: oc = OpPong;
    endcase
    r = $urandom_range(0, 99);
    if (r < 60) len = 64'($urandom_range(0, 8));
    else if (r < 85) len = 64'($urandom_range(9, 40));
    else if (r < 95) len = 64'($urandom_range(41, 125));
    else len = 64'($urandom_range(126, 300));
    if (len > {1'b0, max_len}) len = {1'b0, max_len};
    r = $urandom_range(0, 99);
    if (len > 64'd125) enc = (r < 50) ? Enc16 : Enc64;
    else if (r < 80) enc = Enc7;
    else if (r < 90) enc = Enc16;
    else enc = Enc64;
    send_frame(oc, 1'($urandom), $urandom_range(0, 3) != 0, len, enc, $urandom);
  endtask

  task automatic test_empty_frame();
    set_max_len('0);
    send_frame(OpText, 1'b1, 1'b1, 64'd0, Enc7, 32'h1234_5678);
  endtask

  task automatic test_masked_payload();
    set_max_len({63{1'b1}});
    send_frame(OpBin, 1'b0, 1'b1, 64'd5, Enc7, 32'hA53C_0FF0);
  endtask

  task automatic test_ping_extremes();
    send_byte({1'b1, 3'b000, OpPing});
    send_byte({1'b0, 7'd2});
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  task automatic test_long_length();
    send_frame(OpCont, 1'b1, 1'b0, 64'd1, Enc64, 32'h0);
  endtask

  task automatic test_random_frames();
    int target;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: set_max_len(MaxLenReset);
        1: set_max_len(63'($urandom_range(20, 300)));
        2: set_max_len({63{1'b1}});
        default: set_max_len(63'($urandom_range(0, 8)));
      endcase
      target = bytes_sent + 110;
      while (bytes_sent < target) send_random_frame();
    end
  endtask

  // End the link: close, reserved opcode or oversized length, then feed ignored bytes.
  task automatic test_link_shutdown();
    logic [3:0] oc;
    int         m;
    case ($urandom_range(0, 3))
      0: send_byte({1'($urandom), 3'($urandom_range(0, 7)), OpClose});
      1: begin
        do oc = 4'($urandom_range(0, 15)); while (op_known(oc) || oc == OpClose);
        send_byte({1'($urandom), 3'($urandom_range(0, 7)), oc});
      end
      2: begin
        m = $urandom_range(0, 100);
        set_max_len(63'(m));
        send_byte({1'b1, 3'b000, OpBin});
        send_byte({1'($urandom), 7'($urandom_range(m + 1, 125))});
      end
      default: begin
        set_max_len({63{1'b1}});
        send_byte({1'b1, 3'b000, OpText});
        send_byte({1'($urandom), Len7Ext64});
        send_byte(8'h80 | 8'($urandom));
        for (int i = 0; i < 7; i++) send_byte(8'($urandom));
      end
    endcase
    for (int i = 0; i < 12; i++) send_byte(8'($urandom));
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_frame();
    test_masked_payload();
    test_ping_extremes();
    test_long_length();
    test_random_frames();
    test_link_shutdown();
    in_valid_i <= 1'b0;
    while (deframed_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("websocket_frame_deframer_tb OK");
    end else begin
      $display("websocket_frame_deframer_tb NOT OK");
    end
    $finish;
  end

endmodule
